// File: rtl/core/tcp_speed_variance_top_macros.svh
// Assertion macros for the speed variance block.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef TCP_SPEED_VARIANCE_TOP_MACROS_SVH
`define TCP_SPEED_VARIANCE_TOP_MACROS_SVH

// same-cycle implication
`define TSV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tsv_pkg.sv
// Shared widths, constants and register indexes of the speed variance block.
// No dependencies.
package tsv_pkg;

  localparam int POS_W      = 32;
  localparam int DELTA_W    = 32;
  localparam int SQ_W       = 66;
  localparam int ROOT_W     = 41;
  localparam int RATE_W     = 10;
  localparam int K_W        = 17;
  localparam int SPDP_W     = 58;
  localparam int SPEED_W    = 32;
  localparam int LIMIT_W    = 23;
  localparam int CNT_W      = 17;
  localparam int SUM_W      = 40;
  localparam int SSQ_W      = 62;
  localparam int A_W        = 79;
  localparam int B_W        = 80;
  localparam int N2_W       = 33;
  localparam int DIVIDEND_W = 63;
  localparam int DIVISOR_W  = 33;
  localparam int VAR_W      = 32;
  localparam int FRAC_SH    = 16;
  localparam int IDX_W      = 8;
  localparam int MAX_STEPS  = 65536;

  localparam logic [IDX_W-1:0] REG_SAMPLE_RATE   = 8'd0;
  localparam logic [IDX_W-1:0] REG_OUTLIER_LIMIT = 8'd1;

  localparam logic [RATE_W-1:0]  RATE_RESET  = 10'd10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd524288;

endpackage

// File: rtl/core/tsv_smul.sv
// Bit-serial shift-add multiply-accumulate: one multiplier bit per cycle.
// Uses tsv_pkg for default widths.
module tsv_smul #(
  parameter int MW = tsv_pkg::DELTA_W,
  parameter int NW = tsv_pkg::DELTA_W,
  parameter int PW = tsv_pkg::SQ_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [PW-1:0] acc_i,
  input  logic [MW-1:0] mcand_i,
  input  logic [NW-1:0] mplier_i,
  output logic          busy_o,
  output logic [PW-1:0] prod_o
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic [PW-1:0] acc_q;
  logic [PW-1:0] mc_q;
  logic [NW-1:0] mp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= acc_i;
      mc_q  <= PW'(mcand_i);
      mp_q  <= mplier_i;
    end else if (cnt_q != '0) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= mc_q << 1;
      mp_q <= mp_q >> 1;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign prod_o = acc_q;

endmodule

// File: rtl/core/tsv_sqrt.sv
// Bit-serial integer square root: one root bit per cycle, restoring form.
// Uses tsv_pkg for the default root width.
module tsv_sqrt #(
  parameter int RW = tsv_pkg::ROOT_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*RW-1:0] rad_i,
  output logic            busy_o,
  output logic [RW-1:0]   root_o
);

  localparam int CW = $clog2(RW + 1);

  logic [CW-1:0]   cnt_q;
  logic [2*RW-1:0] rad_q;
  logic [RW+2:0]   rem_q;
  logic [RW-1:0]   root_q;
  logic [RW+2:0]   rem_sh;
  logic [RW+2:0]   trial;
  logic            ge;

  assign rem_sh = {rem_q[RW:0], rad_q[2*RW-1:2*RW-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(RW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[RW-2:0], ge};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;

endmodule

// File: rtl/core/tsv_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Uses tsv_pkg for default widths.
module tsv_div #(
  parameter int NW = tsv_pkg::DIVIDEND_W,
  parameter int DW = tsv_pkg::DIVISOR_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic [NW-1:0] quot_o
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dvs_q;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          ge;

  assign rem_sh  = {rem_q, quo_q[NW-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;

endmodule

// File: rtl/core/tcp_speed_variance_top.sv
// Speed variance top: step speed per position, outlier drop, variance per run.
// One item in flight: a later item of a run passes the serial squarer, root and speed multiplier,
// and a kept step also the square multiplier; the first item of a run only stores its position.
// An item marked last then runs the serial products and divide if steps were kept, else
// goes straight to the output state; output stalls hold it there before the result register loads.
// Reset: asynchronous, clears run state and loads register defaults.
module tcp_speed_variance_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [95:0]                   s_axis_tdata,  // pos_x, pos_y, pos_z
  input  logic                          s_axis_tlast,  // last
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [55:0]                   m_axis_tdata,  // variance, kept_count, valid_res, pad
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tsv_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [tsv_pkg::LIMIT_W-1:0]   cfg_data_i
);

  `include "tcp_speed_variance_top_macros.svh"

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SQ_GO   = 4'd1;
  localparam logic [3:0] ST_SQ_WAIT = 4'd2;
  localparam logic [3:0] ST_RT_GO   = 4'd3;
  localparam logic [3:0] ST_RT_WAIT = 4'd4;
  localparam logic [3:0] ST_SP_GO   = 4'd5;
  localparam logic [3:0] ST_SP_WAIT = 4'd6;
  localparam logic [3:0] ST_SS_GO   = 4'd7;
  localparam logic [3:0] ST_SS_WAIT = 4'd8;
  localparam logic [3:0] ST_FIN     = 4'd9;
  localparam logic [3:0] ST_PR_WAIT = 4'd10;
  localparam logic [3:0] ST_DV_GO   = 4'd11;
  localparam logic [3:0] ST_DV_WAIT = 4'd12;
  localparam logic [3:0] ST_OUT     = 4'd13;

  function automatic logic [tsv_pkg::DELTA_W-1:0] abs_delta(
    logic [tsv_pkg::POS_W-1:0] a,
    logic [tsv_pkg::POS_W-1:0] b
  );
    logic [tsv_pkg::POS_W:0] diff;
    diff = {1'b0, a ^ 32'h8000_0000} - {1'b0, b ^ 32'h8000_0000};
    return diff[tsv_pkg::POS_W] ? tsv_pkg::DELTA_W'(-diff) : diff[tsv_pkg::DELTA_W-1:0];
  endfunction

  logic [3:0] state_q, state_d;

  logic [tsv_pkg::RATE_W-1:0]  rate_q;
  logic [tsv_pkg::LIMIT_W-1:0] limit_q;

  logic [tsv_pkg::POS_W-1:0]   px_q, py_q, pz_q;
  logic                        have_prev_q;
  logic                        last_q;
  logic [1:0]                  axis_q;
  logic [tsv_pkg::DELTA_W-1:0] dx_q, dy_q, dz_q;
  logic [tsv_pkg::CNT_W-1:0]   cnt_q;
  logic [tsv_pkg::SUM_W-1:0]   sum_q;
  logic [tsv_pkg::SSQ_W-1:0]   ssq_q;
  logic [tsv_pkg::SPEED_W-1:0] spd_q;
  logic [tsv_pkg::VAR_W-1:0]   var_q;
  logic                        m_valid_q;
  logic [55:0]                 m_data_q;

  logic in_fire, out_free, keep;
  logic [tsv_pkg::POS_W-1:0]   in_x, in_y, in_z;
  logic [tsv_pkg::K_W-1:0]     k_rate;
  logic [tsv_pkg::SPEED_W-1:0] spd;
  logic [tsv_pkg::DELTA_W-1:0] sq_op;
  logic [tsv_pkg::SQ_W-1:0]    sq_acc, sq_prod;
  logic [tsv_pkg::ROOT_W-1:0]  root;
  logic [tsv_pkg::SPDP_W-1:0]  sp_prod;
  logic [tsv_pkg::SSQ_W-1:0]   ss_prod;
  logic [tsv_pkg::A_W-1:0]     a_prod;
  logic [tsv_pkg::B_W-1:0]     b_prod;
  logic [tsv_pkg::N2_W-1:0]    n2_prod;
  logic [tsv_pkg::B_W-1:0]     diff;
  logic [tsv_pkg::DIVIDEND_W-1:0] quot;
  logic sq_busy, rt_busy, sp_busy, ss_busy, a_busy, b_busy, n2_busy, dv_busy;
  logic fin_go;

  assign in_x = s_axis_tdata[31:0];
  assign in_y = s_axis_tdata[63:32];
  assign in_z = s_axis_tdata[95:64];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign k_rate = tsv_pkg::K_W'({rate_q, 6'b0}) + tsv_pkg::K_W'({rate_q, 5'b0})
                + tsv_pkg::K_W'({rate_q, 2'b0});

  assign spd  = (sp_prod[tsv_pkg::SPDP_W-1:48] != '0) ? '1 : sp_prod[47:16];
  assign keep = (spd <= tsv_pkg::SPEED_W'(limit_q))
             && (cnt_q < tsv_pkg::CNT_W'(tsv_pkg::MAX_STEPS));

  assign sq_op  = (axis_q == 2'd0) ? dx_q : ((axis_q == 2'd1) ? dy_q : dz_q);
  assign sq_acc = (axis_q == 2'd0) ? '0 : sq_prod;
  assign fin_go = (state_q == ST_FIN) && (cnt_q != '0);
  assign diff   = tsv_pkg::B_W'(a_prod) - b_prod;

  tsv_smul #(
    .MW(tsv_pkg::DELTA_W), .NW(tsv_pkg::DELTA_W), .PW(tsv_pkg::SQ_W)
  ) u_sq (
    .clk_i, .rst_ni,
    .start_i (state_q == ST_SQ_GO),
    .acc_i   (sq_acc),
    .mcand_i (sq_op),
    .mplier_i(sq_op),
    .busy_o  (sq_busy),
    .prod_o  (sq_prod)
  );

  tsv_sqrt #(.RW(tsv_pkg::ROOT_W)) u_rt (
    .clk_i, .rst_ni,
    .start_i(state_q == ST_RT_GO),
    .rad_i  ({sq_prod, {tsv_pkg::FRAC_SH{1'b0}}}),
    .busy_o (rt_busy),
    .root_o (root)
  );

  tsv_smul #(
    .MW(tsv_pkg::ROOT_W), .NW(tsv_pkg::K_W), .PW(tsv_pkg::SPDP_W)
  ) u_sp (
    .clk_i, .rst_ni,
    .start_i (state_q == ST_SP_GO),
    .acc_i   ('0),
    .mcand_i (root),
    .mplier_i(k_rate),
    .busy_o  (sp_busy),
    .prod_o  (sp_prod)
  );

  tsv_smul #(
    .MW(tsv_pkg::LIMIT_W), .NW(tsv_pkg::LIMIT_W), .PW(tsv_pkg::SSQ_W)
  ) u_ss (
    .clk_i, .rst_ni,
    .start_i (state_q == ST_SS_GO),
    .acc_i   (ssq_q),
    .mcand_i (spd_q[tsv_pkg::LIMIT_W-1:0]),
    .mplier_i(spd_q[tsv_pkg::LIMIT_W-1:0]),
    .busy_o  (ss_busy),
    .prod_o  (ss_prod)
  );

  tsv_smul #(
    .MW(tsv_pkg::SSQ_W), .NW(tsv_pkg::CNT_W), .PW(tsv_pkg::A_W)
  ) u_a (
    .clk_i, .rst_ni,
    .start_i (fin_go),
    .acc_i   ('0),
    .mcand_i (ssq_q),
    .mplier_i(cnt_q),
    .busy_o  (a_busy),
    .prod_o  (a_prod)
  );

  tsv_smul #(
    .MW(tsv_pkg::SUM_W), .NW(tsv_pkg::SUM_W), .PW(tsv_pkg::B_W)
  ) u_b (
    .clk_i, .rst_ni,
    .start_i (fin_go),
    .acc_i   ('0),
    .mcand_i (sum_q),
    .mplier_i(sum_q),
    .busy_o  (b_busy),
    .prod_o  (b_prod)
  );

  tsv_smul #(
    .MW(tsv_pkg::CNT_W), .NW(tsv_pkg::CNT_W), .PW(tsv_pkg::N2_W)
  ) u_n2 (
    .clk_i, .rst_ni,
    .start_i (fin_go),
    .acc_i   ('0),
    .mcand_i (cnt_q),
    .mplier_i(cnt_q),
    .busy_o  (n2_busy),
    .prod_o  (n2_prod)
  );

  tsv_div #(.NW(tsv_pkg::DIVIDEND_W), .DW(tsv_pkg::DIVISOR_W)) u_dv (
    .clk_i, .rst_ni,
    .start_i   (state_q == ST_DV_GO),
    .dividend_i(diff[tsv_pkg::DIVIDEND_W+tsv_pkg::FRAC_SH-1:tsv_pkg::FRAC_SH]),
    .divisor_i (n2_prod),
    .busy_o    (dv_busy),
    .quot_o    (quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (have_prev_q) begin
            state_d = ST_SQ_GO;
          end else if (s_axis_tlast) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SQ_GO:   state_d = ST_SQ_WAIT;
      ST_SQ_WAIT: begin
        if (!sq_busy) begin
          state_d = (axis_q == 2'd2) ? ST_RT_GO : ST_SQ_GO;
        end
      end
      ST_RT_GO:   state_d = ST_RT_WAIT;
      ST_RT_WAIT: begin
        if (!rt_busy) begin
          state_d = ST_SP_GO;
        end
      end
      ST_SP_GO:   state_d = ST_SP_WAIT;
      ST_SP_WAIT: begin
        if (!sp_busy) begin
          if (keep) begin
            state_d = ST_SS_GO;
          end else begin
            state_d = last_q ? ST_FIN : ST_IDLE;
          end
        end
      end
      ST_SS_GO:   state_d = ST_SS_WAIT;
      ST_SS_WAIT: begin
        if (!ss_busy) begin
          state_d = last_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN:     state_d = (cnt_q == '0) ? ST_OUT : ST_PR_WAIT;
      ST_PR_WAIT: begin
        if (!a_busy && !b_busy && !n2_busy) begin
          state_d = ST_DV_GO;
        end
      end
      ST_DV_GO:   state_d = ST_DV_WAIT;
      ST_DV_WAIT: begin
        if (!dv_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rate_q      <= tsv_pkg::RATE_RESET;
      limit_q     <= tsv_pkg::LIMIT_RESET;
      px_q        <= '0;
      py_q        <= '0;
      pz_q        <= '0;
      have_prev_q <= 1'b0;
      cnt_q       <= '0;
      sum_q       <= '0;
      ssq_q       <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          tsv_pkg::REG_SAMPLE_RATE:   rate_q  <= cfg_data_i[tsv_pkg::RATE_W-1:0];
          tsv_pkg::REG_OUTLIER_LIMIT: limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire) begin
        px_q        <= in_x;
        py_q        <= in_y;
        pz_q        <= in_z;
        have_prev_q <= 1'b1;
      end
      if (state_q == ST_SP_WAIT && !sp_busy && keep) begin
        cnt_q <= cnt_q + 1'b1;
        sum_q <= sum_q + tsv_pkg::SUM_W'(spd);
      end
      if (state_q == ST_SS_WAIT && !ss_busy) begin
        ssq_q <= ss_prod;
      end
      if (state_q == ST_OUT && out_free) begin
        px_q        <= '0;
        py_q        <= '0;
        pz_q        <= '0;
        have_prev_q <= 1'b0;
        cnt_q       <= '0;
        sum_q       <= '0;
        ssq_q       <= '0;
        m_valid_q   <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      last_q <= s_axis_tlast;
      axis_q <= 2'd0;
      dx_q   <= abs_delta(in_x, px_q);
      dy_q   <= abs_delta(in_y, py_q);
      dz_q   <= abs_delta(in_z, pz_q);
    end
    if (state_q == ST_SQ_WAIT && !sq_busy && axis_q != 2'd2) begin
      axis_q <= axis_q + 1'b1;
    end
    if (state_q == ST_SP_WAIT && !sp_busy) begin
      spd_q <= spd;
    end
    if (state_q == ST_FIN) begin
      var_q <= '0;
    end
    if (state_q == ST_DV_WAIT && !dv_busy) begin
      var_q <= (quot[tsv_pkg::DIVIDEND_W-1:tsv_pkg::VAR_W] != '0) ? '1
             : quot[tsv_pkg::VAR_W-1:0];
    end
    if (state_q == ST_OUT && out_free) begin
      m_data_q <= {6'b0, (cnt_q != '0), cnt_q, var_q};
    end
  end

  `TSV_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= tsv_pkg::CNT_W'(tsv_pkg::MAX_STEPS), "kept count above maximum")
  `TSV_ASSERT_NXT(a_run_clear, state_q == ST_OUT && out_free, cnt_q == '0 && !have_prev_q && m_axis_tvalid, "run state not cleared after result")
  `TSV_ASSERT_IMP(a_out_src, $rose(m_axis_tvalid), $past(state_q) == ST_OUT, "result raised outside output state")

endmodule

// File: test/tb_tcp_speed_variance_top.sv
// Self-checking testbench for tcp_speed_variance_top: position runs in, per-run
// speed variance out, checked against an in-bench predictor of the same fixed point.
// Depends on tsv_pkg and the top level RTL only.
module tb_tcp_speed_variance_top;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 320;
  localparam int TIMEOUT_UNITS = 20_000_000;
  localparam int RANDOM_ITEMS  = 750;
  localparam int MAX_REPORTS   = 10;
  localparam int ROOT_TOP      = 42;
  localparam int RUNS_PER_CFG  = 8;
  localparam longint unsigned CM_PER_M   = 100;
  localparam longint unsigned REACH_CAP  = 64'd1 << 28;
  localparam longint unsigned REACH_FREE = 64'd1 << 20;

  localparam logic [tsv_pkg::IDX_W-1:0]   REG_UNMAPPED_LOW = 8'd2;
  localparam logic [tsv_pkg::IDX_W-1:0]   REG_UNMAPPED_TOP = 8'hFF;
  localparam logic [tsv_pkg::RATE_W-1:0]  RATE_TOP  = 10'd1000;
  localparam logic [tsv_pkg::LIMIT_W-1:0] LIMIT_TOP = 23'd6553600;
  localparam logic [tsv_pkg::POS_W-1:0]   POS_MIN   = 32'h8000_0000;
  localparam logic [tsv_pkg::POS_W-1:0]   POS_MAX   = 32'h7FFF_FFFF;
  localparam logic [tsv_pkg::POS_W-1:0]   POS_NEG1  = 32'hFFFF_FFFF;

  localparam int CNT_LSB  = tsv_pkg::VAR_W;
  localparam int FLAG_LSB = tsv_pkg::VAR_W + tsv_pkg::CNT_W;

  typedef struct packed {
    logic [tsv_pkg::VAR_W-1:0] variance;
    logic [tsv_pkg::CNT_W-1:0] kept_count;
    logic                      valid_res;
  } run_stats_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [95:0]                  s_axis_tdata;   // pos_x, pos_y, pos_z
  logic                         s_axis_tlast;   // last
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [55:0]                  m_axis_tdata;   // variance, kept_count, valid_res, pad
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [tsv_pkg::IDX_W-1:0]    cfg_index_i;
  logic [tsv_pkg::LIMIT_W-1:0]  cfg_data_i;

  tcp_speed_variance_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  logic [tsv_pkg::RATE_W-1:0]  model_rate  = tsv_pkg::RATE_RESET;
  logic [tsv_pkg::LIMIT_W-1:0] model_limit = tsv_pkg::LIMIT_RESET;
  logic [tsv_pkg::POS_W-1:0]   prev_x = '0, prev_y = '0, prev_z = '0;
  logic                        have_prev = 1'b0;
  logic [tsv_pkg::CNT_W-1:0]   run_count = '0;
  logic [tsv_pkg::SUM_W-1:0]   run_sum = '0;
  logic [tsv_pkg::SSQ_W-1:0]   run_sq_sum = '0;

  run_stats_t expected_stats[$];
  int mismatches   = 0;
  int results_seen = 0;
  int items_sent   = 0;
  int runs_sent    = 0;
  int cfg_writes   = 0;
  int burst_left   = 1;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [tsv_pkg::DELTA_W:0] axis_distance(logic [tsv_pkg::POS_W-1:0] a,
                                                              logic [tsv_pkg::POS_W-1:0] b);
    logic signed [tsv_pkg::POS_W+1:0] d;
    d = $signed({{2{a[tsv_pkg::POS_W-1]}}, a}) - $signed({{2{b[tsv_pkg::POS_W-1]}}, b});
    return d[tsv_pkg::POS_W+1] ? (tsv_pkg::DELTA_W+1)'(-d) : d[tsv_pkg::DELTA_W:0];
  endfunction

  function automatic logic [tsv_pkg::SPEED_W-1:0] step_speed(logic [tsv_pkg::POS_W-1:0] x,
                                                             logic [tsv_pkg::POS_W-1:0] y,
                                                             logic [tsv_pkg::POS_W-1:0] z);
    logic [127:0] dx, dy, dz, sq, cand;
    logic [63:0]  root, rate64, scaled;
    int b;
    dx = axis_distance(x, prev_x);
    dy = axis_distance(y, prev_y);
    dz = axis_distance(z, prev_z);
    sq = (dx * dx + dy * dy + dz * dz) << tsv_pkg::FRAC_SH;
    root = '0;
    for (b = ROOT_TOP; b >= 0; b--) begin
      cand = {64'd0, root} | (128'd1 << b);
      if (cand * cand <= sq) root = cand[63:0];
    end
    rate64 = model_rate;
    scaled = (root * (rate64 * CM_PER_M)) >> tsv_pkg::FRAC_SH;
    return (scaled > 64'hFFFF_FFFF) ? '1 : scaled[tsv_pkg::SPEED_W-1:0];
  endfunction

  task automatic track_position(logic [tsv_pkg::POS_W-1:0] x, logic [tsv_pkg::POS_W-1:0] y,
                                logic [tsv_pkg::POS_W-1:0] z, logic last_i);
    logic [tsv_pkg::SPEED_W-1:0] speed;
    logic [127:0] n128, sum128, ssq128, spread, quot;
    run_stats_t stats;
    if (have_prev) begin
      speed = step_speed(x, y, z);
      if (speed <= model_limit && run_count < tsv_pkg::MAX_STEPS) begin
        run_count  = run_count + 1'b1;
        run_sum    = run_sum + speed;
        run_sq_sum = run_sq_sum + speed * speed;
      end
    end
    prev_x = x;
    prev_y = y;
    prev_z = z;
    have_prev = 1'b1;
    if (last_i) begin
      stats.variance   = '0;
      stats.kept_count = run_count;
      stats.valid_res  = (run_count != 0);
      if (run_count != 0) begin
        n128   = run_count;
        sum128 = run_sum;
        ssq128 = run_sq_sum;
        spread = n128 * ssq128 - sum128 * sum128;
        quot   = (spread >> tsv_pkg::FRAC_SH) / (n128 * n128);
        stats.variance = (quot > 128'hFFFF_FFFF) ? '1 : quot[tsv_pkg::VAR_W-1:0];
      end
      expected_stats.insert(expected_stats.size(), stats);
      prev_x = '0;
      prev_y = '0;
      prev_z = '0;
      have_prev  = 1'b0;
      run_count  = '0;
      run_sum    = '0;
      run_sq_sum = '0;
    end
  endtask

  task automatic send_position(logic [tsv_pkg::POS_W-1:0] x, logic [tsv_pkg::POS_W-1:0] y,
                               logic [tsv_pkg::POS_W-1:0] z, logic last_i);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    s_axis_tlast  <= last_i;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_position(x, y, z, last_i);
    items_sent++;
    if (last_i) runs_sent++;
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_stats.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(logic [tsv_pkg::IDX_W-1:0] idx,
                                logic [tsv_pkg::LIMIT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == tsv_pkg::REG_SAMPLE_RATE) model_rate = data[tsv_pkg::RATE_W-1:0];
    else if (idx == tsv_pkg::REG_OUTLIER_LIMIT) model_limit = data;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(logic [tsv_pkg::RATE_W-1:0] rate,
                                logic [tsv_pkg::LIMIT_W-1:0] limit);
    settle();
    write_register(tsv_pkg::REG_SAMPLE_RATE, rate);
    write_register(tsv_pkg::REG_OUTLIER_LIMIT, limit);
  endtask

  function automatic logic [tsv_pkg::POS_W-1:0] random_offset(longint unsigned span);
    logic [tsv_pkg::POS_W-1:0] mag;
    mag = $urandom_range(0, span[31:0]);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic random_run(int len);
    logic [tsv_pkg::POS_W-1:0] px, py, pz;
    longint unsigned reach, span;
    int kind;
    if (model_rate == 0) reach = REACH_FREE;
    else reach = (longint'(model_limit) * 256) / (longint'(model_rate) * CM_PER_M) + 1;
    if (reach > REACH_CAP) reach = REACH_CAP;
    px = $urandom;
    py = $urandom;
    pz = $urandom;
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
          px = $urandom;
          py = $urandom;
          pz = $urandom;
        end else begin
          span = (kind < 5) ? reach * 4 : reach;
          px = px + random_offset(span);
          py = py + random_offset(span);
          pz = pz + random_offset(span);
        end
      end
      send_position(px, py, pz, i == len - 1);
    end
  endtask

  task automatic test_short_runs();
    send_position(32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F, 1'b1);
    send_position(32'h0000_4000, 32'hFFFF_C000, 32'h0000_0001, 1'b0);
    send_position(32'h0000_4000, 32'hFFFF_C000, 32'h0000_0001, 1'b1);
    send_position(32'd0, 32'd0, 32'd0, 1'b0);
    send_position(32'd50000, 32'd0, 32'd0, 1'b0);
    send_position(32'd50000, 32'd20000, 32'd0, 1'b0);
    send_position(32'd50000, 32'd20000, -32'sd30000, 1'b1);
    send_position(32'd0, 32'd0, 32'd0, 1'b0);
    send_position(32'd200000, 32'd0, 32'd0, 1'b0);
    send_position(32'd200000, 32'd0, 32'd0, 1'b1);
  endtask

  task automatic test_extreme_positions();
    apply_settings(RATE_TOP, LIMIT_TOP);
    send_position(POS_MIN, POS_MIN, POS_MIN, 1'b0);
    send_position(POS_MAX, POS_MAX, POS_MAX, 1'b0);
    send_position(32'd0, 32'd0, 32'd0, 1'b0);
    send_position(POS_NEG1, POS_NEG1, POS_NEG1, 1'b1);
  endtask

  task automatic test_limit_edges();
    apply_settings(10'd1, 23'd0);
    send_position(32'd0, 32'd0, 32'd0, 1'b0);
    send_position(32'd1, 32'd0, 32'd0, 1'b0);
    send_position(32'd4, 32'd0, 32'd0, 1'b0);
    send_position(32'd4, 32'd0, 32'd0, 1'b1);
    apply_settings(10'd0, 23'd0);
    send_position(POS_MIN, POS_MAX, POS_MIN, 1'b0);
    send_position(POS_MAX, POS_MIN, POS_MAX, 1'b0);
    send_position(32'd0, 32'd0, 32'd0, 1'b1);
  endtask

  task automatic test_unmapped_index();
    settle();
    write_register(REG_UNMAPPED_LOW, '1);
    write_register(REG_UNMAPPED_TOP, '0);
    send_position(32'd0, 32'd0, 32'd0, 1'b0);
    send_position(32'd1000, 32'd0, 32'd0, 1'b1);
    apply_settings(tsv_pkg::RATE_RESET, tsv_pkg::LIMIT_RESET);
  endtask

  task automatic test_random_runs();
    int stop_at, runs_here, len, pick;
    logic [tsv_pkg::RATE_W-1:0]  rate;
    logic [tsv_pkg::LIMIT_W-1:0] limit;
    stop_at   = items_sent + RANDOM_ITEMS;
    runs_here = 0;
    while (items_sent < stop_at) begin
      if (runs_here % RUNS_PER_CFG == 0 && runs_here != 0) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) rate = '0;
        else if (pick < 4) rate = 10'd1;
        else if (pick < 7) rate = RATE_TOP;
        else rate = tsv_pkg::RATE_W'($urandom_range(1, RATE_TOP));
        pick = $urandom_range(0, 19);
        if (pick < 2) limit = '0;
        else if (pick < 5) limit = LIMIT_TOP;
        else if (pick < 7) limit = tsv_pkg::LIMIT_RESET;
        else limit = tsv_pkg::LIMIT_W'($urandom_range(0, LIMIT_TOP));
        apply_settings(rate, limit);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) len = 1;
      else if (pick == 1) len = $urandom_range(41, 120);
      else len = $urandom_range(2, 40);
      random_run(len);
      runs_here++;
    end
  endtask

  initial begin
    int hi, lo;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 4) == 0) begin
        hi = $urandom_range(50, 200);
        lo = 0;
      end else begin
        hi = $urandom_range(1, 6);
        lo = $urandom_range(1, 40);
      end
      repeat (hi) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end
      repeat (lo) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    run_stats_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.variance   = m_axis_tdata[tsv_pkg::VAR_W-1:0];
      got.kept_count = m_axis_tdata[CNT_LSB +: tsv_pkg::CNT_W];
      got.valid_res  = m_axis_tdata[FLAG_LSB];
      results_seen++;
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: variance %h kept %0d valid %0b",
                   got.variance, got.kept_count, got.valid_res);
      end else begin
        want = expected_stats.pop_front();
        if (got.variance !== want.variance || got.kept_count !== want.kept_count ||
            got.valid_res !== want.valid_res) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: expected variance %h kept %0d valid %0b, got %h %0d %0b",
                     results_seen, want.variance, want.kept_count, want.valid_res,
                     got.variance, got.kept_count, got.valid_res);
        end
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_short_runs();
    test_extreme_positions();
    test_limit_edges();
    test_unmapped_index();
    test_random_runs();
    settle();

    $display("Covered %0d positions in %0d runs, %0d results checked, %0d register writes",
             items_sent, runs_sent, results_seen, cfg_writes);
    $display("Mismatching or unexpected results: %0d", mismatches);
    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
